// ===== design/stc_pkg.sv =====
// Shared types and constants of the scrolling text console.
// Used by every module of the block; depends on nothing else.
package stc_pkg;

    localparam int POS_W = 11;

    localparam logic [1:0] ADDR_TEXT_ATTR = 2'd0;

    localparam logic [1:0] ACT_PUT   = 2'd0;
    localparam logic [1:0] ACT_CLEAR = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_RETURN    = 8'h0D;

    localparam logic [15:0] BLANK_CELL = 16'h0720;
    localparam logic [7:0]  ATTR_RESET = 8'h07;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] char_code;
        logic       end_of_write;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } cmd_t;

    typedef struct packed {
        logic [15:0] cell_value;
        logic [10:0] cursor_pos;
    } rsp_t;

    typedef enum logic [2:0] {
        OP_PRINT,
        OP_NEWLINE,
        OP_RETURN,
        OP_BACKSPACE,
        OP_TAB,
        OP_CLEAR,
        OP_READ,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] char_code;
        logic       end_of_write;
        logic [4:0] read_row;
        logic [6:0] read_col;
        logic       rd_ok;
    } entry_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_FILL,
        BK_READ
    } back_state_t;

endpackage

// ===== design/stc_front.sv =====
// Front end of the console: takes command transfers and classifies them.
// Depends on stc_pkg; feeds the stc_queue.
module stc_front #(
    parameter int ROWS    = 25,
    parameter int COLUMNS = 80
) (
    input  logic            cmd_valid,
    output logic            cmd_stall,
    input  stc_pkg::cmd_t   cmd,
    input  logic            q_full,
    output logic            q_push,
    output stc_pkg::entry_t q_entry
);

    stc_pkg::op_t op;

    always_comb
    begin
        case (cmd.action)
            stc_pkg::ACT_PUT:
            begin
                case (cmd.char_code)
                    stc_pkg::CH_NEWLINE:   op = stc_pkg::OP_NEWLINE;
                    stc_pkg::CH_RETURN:    op = stc_pkg::OP_RETURN;
                    stc_pkg::CH_BACKSPACE: op = stc_pkg::OP_BACKSPACE;
                    stc_pkg::CH_TAB:       op = stc_pkg::OP_TAB;
                    default:               op = stc_pkg::OP_PRINT;
                endcase
            end
            stc_pkg::ACT_CLEAR: op = stc_pkg::OP_CLEAR;
            stc_pkg::ACT_READ:  op = stc_pkg::OP_READ;
            default:            op = stc_pkg::OP_NOP;
        endcase
    end

    // A read outside the screen is flagged here so the back end returns zero.
    assign q_entry.op           = op;
    assign q_entry.char_code    = cmd.char_code;
    assign q_entry.end_of_write = cmd.end_of_write;
    assign q_entry.read_row     = cmd.read_row;
    assign q_entry.read_col     = cmd.read_col;
    assign q_entry.rd_ok        = (int'(cmd.read_row) < ROWS) && (int'(cmd.read_col) < COLUMNS);

    assign cmd_stall = q_full;
    assign q_push    = cmd_valid && !q_full;

endmodule

// ===== design/stc_queue.sv =====
// Two-entry queue of classified commands between front and back end.
// Depends on stc_pkg for the entry type.
module stc_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  stc_pkg::entry_t push_entry,
    output logic            full,
    input  logic            pop,
    output stc_pkg::entry_t head,
    output logic            nempty
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    stc_pkg::entry_t      slot_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [PTR_W:0]       count_reg;

    assign full   = (count_reg == (PTR_W+1)'(DEPTH));
    assign nempty = (count_reg != '0);
    assign head   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== design/stc_back.sv =====
// Back end of the console: screen memory, cursor, scrolling and the result register.
// Depends on stc_pkg; takes classified commands from stc_queue.
module stc_back #(
    parameter int ROWS    = 25,
    parameter int COLUMNS = 80
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [7:0]      text_attr,
    input  logic            q_nempty,
    input  stc_pkg::entry_t head,
    output logic            q_pop,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output stc_pkg::rsp_t   rsp
);

    localparam int RW = $clog2(ROWS);
    localparam int CW = $clog2(COLUMNS);
    localparam int AW = $clog2(ROWS * COLUMNS);
    localparam int PW = stc_pkg::POS_W;
    localparam logic [RW:0]   ROWS_W   = (RW+1)'(ROWS);
    localparam logic [CW:0]   TAB_STEP = (CW+1)'(8);
    localparam logic [CW:0]   TAB_MASK = ~((CW+1)'(7));

    logic [15:0] screen_mem [ROWS * COLUMNS];
    logic [15:0] rdata_reg;

    stc_pkg::back_state_t state_reg, state_next;
    logic [RW-1:0]   top_reg, top_next;
    logic [RW-1:0]   crow_reg, crow_next;
    logic [CW-1:0]   ccol_reg, ccol_next;
    logic [PW-1:0]   shown_reg, shown_next;
    logic [ROWS-1:0] row_valid_reg, row_valid_next;
    logic [CW-1:0]   fill_col_reg, fill_col_next;
    logic [RW-1:0]   fill_row_reg, fill_row_next;
    logic            rd_ok_reg, rd_ok_next;
    logic            rd_blank_reg, rd_blank_next;
    logic            rsp_valid_reg;
    logic [15:0]     cell_reg;
    logic [PW-1:0]   pos_reg;

    logic [RW-1:0] lrow;
    logic [RW:0]   row_sum;
    logic [RW-1:0] prow;
    logic [CW:0]   tab_col;
    logic          out_free;
    logic          mem_we;
    logic          mem_re;
    logic [RW-1:0] mem_row;
    logic [CW-1:0] mem_col;
    logic [AW-1:0] mem_addr;
    logic [15:0]   mem_wdata;
    logic          res_load;
    logic [15:0]   res_cell;
    logic          do_nl;
    logic          latch;

    assign out_free = !rsp_valid_reg || !rsp_stall;

    // Logical to physical row through the top-row pointer.
    assign lrow    = (head.op == stc_pkg::OP_READ) ? (head.rd_ok ? RW'(head.read_row) : '0)
                                                   : crow_reg;
    assign row_sum = {1'b0, top_reg} + {1'b0, lrow};
    assign prow    = (row_sum >= ROWS_W) ? RW'(row_sum - ROWS_W) : RW'(row_sum);
    assign tab_col = ({1'b0, ccol_reg} + TAB_STEP) & TAB_MASK;

    assign mem_addr = AW'(mem_row) * AW'(COLUMNS) + AW'(mem_col);

    always_comb
    begin
        state_next     = state_reg;
        top_next       = top_reg;
        crow_next      = crow_reg;
        ccol_next      = ccol_reg;
        shown_next     = shown_reg;
        row_valid_next = row_valid_reg;
        fill_col_next  = fill_col_reg;
        fill_row_next  = fill_row_reg;
        rd_ok_next     = rd_ok_reg;
        rd_blank_next  = rd_blank_reg;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_row        = prow;
        mem_col        = ccol_reg;
        mem_wdata      = stc_pkg::BLANK_CELL;
        res_load       = 1'b0;
        res_cell       = '0;
        do_nl          = 1'b0;
        latch          = 1'b0;

        case (state_reg)
            stc_pkg::BK_IDLE:
            begin
                if (q_nempty)
                begin
                    if (head.op == stc_pkg::OP_PRINT && !row_valid_reg[prow])
                    begin
                        // The row still reads blank; write the blanks out before printing.
                        state_next    = stc_pkg::BK_FILL;
                        fill_row_next = prow;
                        fill_col_next = '0;
                    end
                    else if (out_free)
                    begin
                        q_pop = 1'b1;
                        case (head.op)
                            stc_pkg::OP_READ:
                            begin
                                mem_re        = 1'b1;
                                mem_col       = head.rd_ok ? CW'(head.read_col) : '0;
                                rd_ok_next    = head.rd_ok;
                                rd_blank_next = !row_valid_reg[prow];
                                state_next    = stc_pkg::BK_READ;
                            end
                            stc_pkg::OP_CLEAR:
                            begin
                                row_valid_next = '0;
                                top_next       = '0;
                                crow_next      = '0;
                                ccol_next      = '0;
                                latch          = 1'b1;
                                res_load       = 1'b1;
                            end
                            stc_pkg::OP_PRINT:
                            begin
                                mem_we    = 1'b1;
                                mem_wdata = {text_attr, head.char_code};
                                if (ccol_reg == CW'(COLUMNS - 1))
                                begin
                                    do_nl = 1'b1;
                                end
                                else
                                begin
                                    ccol_next = ccol_reg + 1'b1;
                                end
                                latch    = head.end_of_write;
                                res_load = 1'b1;
                            end
                            stc_pkg::OP_NEWLINE:
                            begin
                                do_nl    = 1'b1;
                                latch    = head.end_of_write;
                                res_load = 1'b1;
                            end
                            stc_pkg::OP_RETURN:
                            begin
                                ccol_next = '0;
                                latch     = head.end_of_write;
                                res_load  = 1'b1;
                            end
                            stc_pkg::OP_BACKSPACE:
                            begin
                                if (ccol_reg != '0)
                                begin
                                    ccol_next = ccol_reg - 1'b1;
                                    mem_col   = ccol_reg - 1'b1;
                                    mem_we    = row_valid_reg[prow];
                                end
                                latch    = head.end_of_write;
                                res_load = 1'b1;
                            end
                            stc_pkg::OP_TAB:
                            begin
                                if (int'(tab_col) >= COLUMNS)
                                begin
                                    do_nl = 1'b1;
                                end
                                else
                                begin
                                    ccol_next = CW'(tab_col);
                                end
                                latch    = head.end_of_write;
                                res_load = 1'b1;
                            end
                            default:
                            begin
                                res_load = 1'b1;
                            end
                        endcase
                    end
                end
            end
            stc_pkg::BK_FILL:
            begin
                mem_we  = 1'b1;
                mem_row = fill_row_reg;
                mem_col = fill_col_reg;
                if (fill_col_reg == CW'(COLUMNS - 1))
                begin
                    row_valid_next[fill_row_reg] = 1'b1;
                    state_next = stc_pkg::BK_IDLE;
                end
                else
                begin
                    fill_col_next = fill_col_reg + 1'b1;
                end
            end
            stc_pkg::BK_READ:
            begin
                res_load   = 1'b1;
                res_cell   = !rd_ok_reg ? 16'h0000 :
                             rd_blank_reg ? stc_pkg::BLANK_CELL : rdata_reg;
                state_next = stc_pkg::BK_IDLE;
            end
            default:
            begin
                state_next = stc_pkg::BK_IDLE;
            end
        endcase

        // Scrolling drops the top row: it is marked blank and becomes the new bottom.
        if (do_nl)
        begin
            ccol_next = '0;
            if (crow_reg == RW'(ROWS - 1))
            begin
                row_valid_next[top_reg] = 1'b0;
                top_next = (top_reg == RW'(ROWS - 1)) ? '0 : top_reg + 1'b1;
            end
            else
            begin
                crow_next = crow_reg + 1'b1;
            end
        end

        if (latch)
        begin
            shown_next = PW'(AW'(crow_next) * AW'(COLUMNS) + AW'(ccol_next));
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            screen_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= screen_mem[mem_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= stc_pkg::BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg       <= '0;
            crow_reg      <= '0;
            ccol_reg      <= '0;
            shown_reg     <= '0;
            row_valid_reg <= '0;
            fill_col_reg  <= '0;
            fill_row_reg  <= '0;
            rd_ok_reg     <= 1'b0;
            rd_blank_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            top_reg       <= top_next;
            crow_reg      <= crow_next;
            ccol_reg      <= ccol_next;
            shown_reg     <= shown_next;
            row_valid_reg <= row_valid_next;
            fill_col_reg  <= fill_col_next;
            fill_row_reg  <= fill_row_next;
            rd_ok_reg     <= rd_ok_next;
            rd_blank_reg  <= rd_blank_next;
            if (res_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            cell_reg <= res_cell;
            pos_reg  <= shown_next;
        end
    end

    assign rsp_valid      = rsp_valid_reg;
    assign rsp.cell_value = cell_reg;
    assign rsp.cursor_pos = pos_reg;

`ifndef SYNTHESIS
    a_clear_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && head.op == stc_pkg::OP_CLEAR) |=> (row_valid_reg == '0 && shown_reg == '0))
        else $error("clear did not blank the screen and home the cursor");

    a_fill_marks_row: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == stc_pkg::BK_FILL && fill_col_reg == CW'(COLUMNS - 1))
        |=> (state_reg == stc_pkg::BK_IDLE && row_valid_reg[$past(fill_row_reg)]))
        else $error("row fill finished without marking the row written");

    a_read_answers: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && head.op == stc_pkg::OP_READ) |=> res_load)
        else $error("read did not produce a result in the following cycle");

    a_write_valid_row: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && state_reg == stc_pkg::BK_IDLE) |-> row_valid_reg[mem_row])
        else $error("character written into a row that was never filled");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (int'(crow_reg) < ROWS && int'(ccol_reg) < COLUMNS))
        else $error("cursor left the screen");
`endif

endmodule

// ===== design/scrolling_text_console.sv =====
// Top level of the scrolling text console: configuration port and the
// front end, command queue and back end. Depends on stc_pkg and all stc_ modules.
//
// Usage: commands arrive on the cmd channel (cmd_valid/cmd_stall, payload cmd)
// and each produces exactly one transfer on the rsp channel (rsp_valid/rsp_stall,
// payload rsp) carrying the cell read (zero for non-read commands) and the
// latched hardware cursor position. Commands are classified by a front end and
// held in a two-entry queue, so the sender keeps transferring while the back
// end works or while a result waits in the output register.
// The back end takes each command only once the last one is done; a read
// passes through a second state since the screen memory read data is registered.
// A printable character landing on a row still blank since reset, clear or a
// scroll first writes the COLUMNS cells of that row with blanks. Scrolling
// moves a top-row pointer. Reset clears the cursor, top-row pointer and per-row
// written flags at once; every row then reads blank, so the block takes commands
// right after reset. text_attr resets to 0x07 and is written through the APB
// port at address 0; the user writes it only while the block is idle, which the
// block itself does not enforce. When the receiver stalls, the result register
// holds its value; once the queue fills, cmd_stall rises and the sender waits.
module scrolling_text_console #(
    parameter int ROWS    = 25,
    parameter int COLUMNS = 80
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [1:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  stc_pkg::cmd_t cmd,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output stc_pkg::rsp_t rsp
);

    logic [7:0]      text_attr_reg;
    logic            q_full;
    logic            q_push;
    logic            q_pop;
    logic            q_nempty;
    stc_pkg::entry_t q_entry;
    stc_pkg::entry_t q_head;

    // The only register, text_attr, sits at address 0.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_attr_reg <= stc_pkg::ATTR_RESET;
        end
        else if (psel && penable && pwrite && (paddr == stc_pkg::ADDR_TEXT_ATTR))
        begin
            text_attr_reg <= pwdata[7:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = {24'h000000, text_attr_reg};

    // Front end: classifies each command transfer into an operation.
    stc_front #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_front (
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (q_entry)
    );

    // Decoupling queue between front and back end.
    stc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head       (q_head),
        .nempty     (q_nempty)
    );

    // Back end: screen memory, cursor and scrolling, result register.
    stc_back #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .text_attr (text_attr_reg),
        .q_nempty  (q_nempty),
        .head      (q_head),
        .q_pop     (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for scrolling_text_console: a directed table, then random
// write bursts, reads and clears. Each result is checked against its typed value
// or a cell-level predictor; depends only on stc_pkg and the RTL of the block.
module tb_top;

    // Geometry of the block as built with its default parameters.
    localparam int ROWS  = 25;
    localparam int COLS  = 80;
    localparam int CELLS = ROWS * COLS;
    localparam int POS_W = stc_pkg::POS_W;

    // Hardware tab stops fall on multiples of this width.
    localparam int unsigned TAB_STOP = 8;

    // The block has no name for the fourth action code, which does nothing.
    localparam logic [1:0] ACT_NONE = 2'd3;

    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 9;
    localparam int PHASES         = 4;
    localparam int ITEMS_PER_PHASE = 362;
    // The slowest transfer of a correct block adds up a sender gap, a row fill of
    // COLUMNS cells, a read and a receiver stall. The watchdog allows many times
    // that before it calls the run hung.
    localparam int HANG_LIMIT     = 2000;
    // Only the first mismatches are printed, so a broken block cannot flood the log.
    localparam int PRINT_LIMIT    = 200;

    typedef struct {
        stc_pkg::cmd_t c;
        bit            typed;
        stc_pkg::rsp_t want;
    } table_row_t;

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          psel      = 1'b0;
    logic          penable   = 1'b0;
    logic          pwrite    = 1'b0;
    logic [1:0]    paddr     = '0;
    logic [31:0]   pwdata    = '0;
    logic [31:0]   prdata;
    logic          pready;
    logic          cmd_valid = 1'b0;
    logic          cmd_stall;
    stc_pkg::cmd_t cmd       = '0;
    logic          rsp_valid;
    logic          rsp_stall = 1'b0;
    stc_pkg::rsp_t rsp;

    // Shadow copy of the console: the screen in physical row order, the top-row
    // pointer that scrolling advances, the cursor, the latched hardware cursor and
    // the attribute register.
    logic [15:0]      shadow_screen [CELLS];
    int unsigned      top_ptr;
    int unsigned      cur_row;
    int unsigned      cur_col;
    logic [POS_W-1:0] shown_pos;
    logic [7:0]       shadow_attr;

    // Results that the block owes, oldest first, and the directed stimulus table.
    stc_pkg::rsp_t due_replies [$];
    table_row_t    directed_rows [$];

    int  mismatch_count = 0;
    int  reply_count    = 0;
    bit  send_quiet     = 1'b0;
    bit  recv_quiet     = 1'b0;

    scrolling_text_console i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #HALF_PERIOD clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Maps a logical row, counted from the top of the visible screen, to its
    // place in the shadow array.
    function automatic int unsigned cell_index(int unsigned lrow, int unsigned col);
        return ((top_ptr + lrow) % ROWS) * COLS + col;
    endfunction

    // Blank cells always carry attribute 0x07 and a space, whatever the
    // attribute register holds.
    function automatic void wipe_row(int unsigned prow);
        for (int c = 0; c < COLS; c++)
        begin
            shadow_screen[prow * COLS + c] = stc_pkg::BLANK_CELL;
        end
    endfunction

    // Clear and reset both leave a blank screen with the cursor at home.
    function automatic void blank_console();
        for (int r = 0; r < ROWS; r++)
        begin
            wipe_row(r);
        end
        top_ptr   = 0;
        cur_row   = 0;
        cur_col   = 0;
        shown_pos = '0;
    endfunction

    // Moves to column 0 of the next row. Past the last row the oldest physical
    // row is blanked and becomes the new bottom row, which scrolls the screen up.
    function automatic void line_feed();
        cur_col = 0;
        cur_row++;
        if (cur_row >= ROWS)
        begin
            wipe_row(top_ptr);
            top_ptr = (top_ptr + 1) % ROWS;
            cur_row = ROWS - 1;
        end
    endfunction

    // Applies one command to the shadow console and returns the result that the
    // block must give for it.
    function automatic stc_pkg::rsp_t console_step(stc_pkg::cmd_t c);
        stc_pkg::rsp_t r;
        r = '0;
        case (c.action)
            stc_pkg::ACT_PUT:
            begin
                case (c.char_code)
                    stc_pkg::CH_NEWLINE:
                        line_feed();
                    stc_pkg::CH_RETURN:
                        cur_col = 0;
                    stc_pkg::CH_BACKSPACE:
                    begin
                        // At column 0 a backspace neither moves the cursor nor blanks a cell.
                        if (cur_col > 0)
                        begin
                            cur_col--;
                            shadow_screen[cell_index(cur_row, cur_col)] = stc_pkg::BLANK_CELL;
                        end
                    end
                    stc_pkg::CH_TAB:
                    begin
                        cur_col = (cur_col + TAB_STOP) & ~(TAB_STOP - 1);
                        if (cur_col >= COLS)
                        begin
                            line_feed();
                        end
                    end
                    default:
                    begin
                        shadow_screen[cell_index(cur_row, cur_col)] = {shadow_attr, c.char_code};
                        cur_col++;
                        if (cur_col >= COLS)
                        begin
                            line_feed();
                        end
                    end
                endcase
                if (c.end_of_write)
                begin
                    shown_pos = POS_W'(cur_row * COLS + cur_col);
                end
            end
            stc_pkg::ACT_CLEAR:
                blank_console();
            stc_pkg::ACT_READ:
            begin
                // Coordinates off the screen read as zero.
                if (c.read_row < ROWS && c.read_col < COLS)
                begin
                    r.cell_value = shadow_screen[cell_index(c.read_row, c.read_col)];
                end
            end
            default:
                ;
        endcase
        r.cursor_pos = shown_pos;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        if (mismatch_count < PRINT_LIMIT)
        begin
            $display("MISMATCH at %0t: %s", $time, what);
        end
        mismatch_count++;
    endtask

    // Draws the random wait that each side puts before a transfer; quiet stretches use none.
    function automatic int draw_gap(bit quiet);
        return quiet ? 0 : int'($urandom_range(0, 15));
    endfunction

    task automatic add_row(input logic [1:0] act, input logic [7:0] ch, input logic eow,
                           input logic [4:0] row, input logic [6:0] col, input bit typed,
                           input logic [15:0] want_cell, input logic [POS_W-1:0] pos);
        table_row_t t;
        t.c.action       = act;
        t.c.char_code    = ch;
        t.c.end_of_write = eow;
        t.c.read_row     = row;
        t.c.read_col     = col;
        t.typed          = typed;
        t.want.cell_value = want_cell;
        t.want.cursor_pos = pos;
        directed_rows.push_back(t);
    endtask

    // Offers one command after a random gap and returns at the clock edge at which
    // the transfer took place. The expected result is queued at that edge: either
    // the one typed into the table, or the predictor's. The predictor is stepped
    // in both cases so that its state follows the block.
    task automatic send_cmd(input stc_pkg::cmd_t c, input bit typed, input stc_pkg::rsp_t want);
        int            gap;
        stc_pkg::rsp_t guess;
        if ($urandom_range(0, 49) == 0)
        begin
            send_quiet = !send_quiet;
        end
        gap = draw_gap(send_quiet);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        do
            @(posedge clk);
        while (cmd_stall);
        guess = console_step(c);
        due_replies.push_back(typed ? want : guess);
    endtask

    // Lowers valid, waits for every owed result and then waits out the settle time,
    // so that a stray late result would still be caught.
    task automatic wait_drained(input int settle);
        cmd_valid <= 1'b0;
        while (due_replies.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (settle) @(posedge clk);
    endtask

    // APB write of the attribute register: a setup phase, then an access phase that
    // ends at the edge where pready is seen high.
    task automatic write_attr(input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= stc_pkg::ADDR_TEXT_ATTR;
        pwdata  <= {24'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        shadow_attr = value;
    endtask

    // Random traffic shaped like a processor console stream: bursts of characters
    // whose last one carries end_of_write, with reads, the odd clear and the unused
    // action code between bursts. Every field starts from a fully random value so
    // each bit toggles; the kind of item then overrides the fields that matter.
    task automatic run_random(input int count);
        stc_pkg::cmd_t c;
        int            burst_left;
        int            pick;
        burst_left = 0;
        for (int i = 0; i < count; i++)
        begin
            c.action       = 2'($urandom_range(0, 3));
            c.char_code    = 8'($urandom_range(0, 255));
            c.end_of_write = 1'($urandom_range(0, 1));
            c.read_row     = 5'($urandom_range(0, 31));
            c.read_col     = 7'($urandom_range(0, 127));
            if (burst_left == 0)
            begin
                pick = int'($urandom_range(0, 99));
                if (pick < 50)
                begin
                    // Half of these reads land on the cursor row, where the text changes.
                    c.action   = stc_pkg::ACT_READ;
                    c.read_row = $urandom_range(0, 1) ? 5'(cur_row)
                                                      : 5'($urandom_range(0, ROWS - 1));
                    c.read_col = 7'($urandom_range(0, COLS - 1));
                end
                else if (pick < 58)
                begin
                    c.action = stc_pkg::ACT_READ;
                end
                else if (pick < 59)
                begin
                    c.action = stc_pkg::ACT_CLEAR;
                end
                else if (pick < 61)
                begin
                    c.action = ACT_NONE;
                end
                else
                begin
                    burst_left = int'($urandom_range(1, 24));
                end
            end
            if (burst_left > 0)
            begin
                c.action = stc_pkg::ACT_PUT;
                pick = int'($urandom_range(0, 99));
                if (pick < 12)
                begin
                    c.char_code = stc_pkg::CH_NEWLINE;
                end
                else if (pick < 18)
                begin
                    c.char_code = stc_pkg::CH_TAB;
                end
                else if (pick < 24)
                begin
                    c.char_code = stc_pkg::CH_BACKSPACE;
                end
                else if (pick < 28)
                begin
                    c.char_code = stc_pkg::CH_RETURN;
                end
                // A stray end flag inside a burst is the broken-sequence case.
                c.end_of_write = (burst_left == 1) || ($urandom_range(0, 15) == 0);
                burst_left--;
            end
            send_cmd(c, 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: stalls at random, then checks each transfer against the oldest
    // owed result.
    // ------------------------------------------------------------------
    initial
    begin : reply_side
        stc_pkg::rsp_t want;
        int            gap;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 49) == 0)
            begin
                recv_quiet = !recv_quiet;
            end
            gap = draw_gap(recv_quiet);
            if (gap > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            do
                @(posedge clk);
            while (!rsp_valid);
            reply_count++;
            if (due_replies.size() == 0)
            begin
                report_mismatch($sformatf("result %0d arrived with none owed: cell %h cursor %0d",
                                          reply_count, rsp.cell_value, rsp.cursor_pos));
            end
            else
            begin
                want = due_replies.pop_front();
                if (rsp.cell_value !== want.cell_value)
                begin
                    report_mismatch($sformatf("result %0d cell_value %h, expected %h",
                                              reply_count, rsp.cell_value, want.cell_value));
                end
                if (rsp.cursor_pos !== want.cursor_pos)
                begin
                    report_mismatch($sformatf("result %0d cursor_pos %0d, expected %0d",
                                              reply_count, rsp.cursor_pos, want.cursor_pos));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: the run is called hung when transfers stop on both channels; it
    // then reports a failure and ends the simulation.
    // ------------------------------------------------------------------
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        @(posedge rst_n);
        while (quiet_cycles < HANG_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
        end
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_sequence
        logic [7:0] phase_attr [PHASES];

        blank_console();
        shadow_attr = stc_pkg::ATTR_RESET;

        phase_attr[0] = 8'hFF;
        phase_attr[1] = 8'h00;
        phase_attr[2] = 8'($urandom_range(0, 255));
        phase_attr[3] = 8'($urandom_range(0, 255));

        // Directed table. Rows with a typed result are the ones that follow
        // straight from reset or a clear, the field extremes and the off-screen cases;
        // the rest are left to the predictor.
        // Every cell reads blank after reset, also the bottom right one.
        add_row(stc_pkg::ACT_READ, 8'h00, 1'b0, 5'd0, 7'd0, 1'b1, stc_pkg::BLANK_CELL, '0);
        add_row(stc_pkg::ACT_READ, 8'h00, 1'b0, 5'd24, 7'd79, 1'b1, stc_pkg::BLANK_CELL, '0);
        // Reads off the screen give zero, by row and by column.
        add_row(stc_pkg::ACT_READ, 8'hFF, 1'b1, 5'd31, 7'd0, 1'b1, 16'h0000, '0);
        add_row(stc_pkg::ACT_READ, 8'h00, 1'b0, 5'd0, 7'd127, 1'b1, 16'h0000, '0);
        // The unused action code changes nothing, whatever the other fields hold.
        add_row(ACT_NONE, 8'hFF, 1'b1, 5'd31, 7'd127, 1'b1, 16'h0000, '0);
        // Printable bytes including both ends of the range; only the last one
        // latches the hardware cursor.
        add_row(stc_pkg::ACT_PUT, 8'h48, 1'b0, 5'd0, 7'd0, 1'b0, '0, '0);
        add_row(stc_pkg::ACT_PUT, 8'h00, 1'b0, 5'd0, 7'd0, 1'b0, '0, '0);
        add_row(stc_pkg::ACT_PUT, 8'hFF, 1'b1, 5'd0, 7'd0, 1'b0, '0, '0);
        add_row(stc_pkg::ACT_READ, 8'h00, 1'b0, 5'd0, 7'd0, 1'b0, '0, '0);
        // Backspace blanks the cell it steps back onto with the fixed blank.
        add_row(stc_pkg::ACT_PUT, stc_pkg::CH_BACKSPACE, 1'b1, 5'd0, 7'd0, 1'b0, '0, '0);
        add_row(stc_pkg::ACT_READ, 8'h00, 1'b0, 5'd0, 7'd2, 1'b0, '0, '0);
        // Ten tabs from column 2: nine reach column 72, the tenth runs past the
        // right edge and wraps to the next row.
        for (int t = 0; t < 10; t++)
        begin
            add_row(stc_pkg::ACT_PUT, stc_pkg::CH_TAB, (t == 9), 5'd0, 7'd0, 1'b0, '0, '0);
        end
        // Backspace at column 0 does nothing.
        add_row(stc_pkg::ACT_PUT, stc_pkg::CH_BACKSPACE, 1'b1, 5'd0, 7'd0, 1'b0, '0, '0);
        add_row(stc_pkg::ACT_PUT, 8'h5A, 1'b0, 5'd0, 7'd0, 1'b0, '0, '0);
        add_row(stc_pkg::ACT_PUT, stc_pkg::CH_RETURN, 1'b1, 5'd0, 7'd0, 1'b0, '0, '0);
        add_row(stc_pkg::ACT_PUT, stc_pkg::CH_NEWLINE, 1'b1, 5'd0, 7'd0, 1'b0, '0, '0);
        // Clear latches the home position even with the end flag low.
        add_row(stc_pkg::ACT_CLEAR, 8'h00, 1'b0, 5'd0, 7'd0, 1'b1, 16'h0000, '0);
        add_row(stc_pkg::ACT_READ, 8'h00, 1'b1, 5'd0, 7'd0, 1'b1, stc_pkg::BLANK_CELL, '0);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The directed part runs with the attribute at its reset value.
        foreach (directed_rows[i])
        begin
            send_cmd(directed_rows[i].c, directed_rows[i].typed, directed_rows[i].want);
        end

        // Each random phase starts from an idle block with a new attribute; the
        // first two phases use the extremes of the register.
        for (int p = 0; p < PHASES; p++)
        begin
            wait_drained(4);
            write_attr(phase_attr[p]);
            run_random(ITEMS_PER_PHASE);
        end

        wait_drained(10);

        if (mismatch_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
